>>> src/led_blink_pattern_sequencer_assert.svh
// Assertion macros shared by the LED sequencer RTL.
`ifndef LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define LBPS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("LED sequencer invariant violated");

// A condition that, once seen, implies another in the next cycle.
`define LBPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("LED sequencer next-cycle check violated");

`endif

>>> src/lbps_pkg.sv
`default_nettype none

package lbps_pkg;

   // Mode codes as they appear on mode_sel and mode_now.
   localparam logic [3:0] MODE_OFF       = 4'd0;
   localparam logic [3:0] MODE_FAST      = 4'd1;
   localparam logic [3:0] MODE_BLINK     = 4'd2;
   localparam logic [3:0] MODE_INV       = 4'd3;
   localparam logic [3:0] MODE_TWICE     = 4'd4;
   localparam logic [3:0] MODE_SLOW      = 4'd5;
   localparam logic [3:0] MODE_SLOW_INV  = 4'd6;
   localparam logic [3:0] MODE_STANDBY   = 4'd7;
   localparam logic [3:0] MODE_GLOW      = 4'd8;
   localparam logic [3:0] MODE_ON        = 4'd9;

   // Command codes.
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_SET  = 2'd1;
   localparam logic [1:0] CMD_NEXT = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_ACTIVE_HIGH = 1'b0;
   localparam logic CSR_GLOW_STEP   = 1'b1;

   // Widths and constants.
   localparam int  PHASES_DEFAULT     = 6;
   localparam int  COUNT_BITS_DEFAULT = 16;
   localparam int  DUR_BITS           = 14;
   localparam int  DUTY_BITS          = 10;
   localparam logic [DUTY_BITS-1:0] GLOW_STEP_RESET = 10'd60;
   localparam logic [DUTY_BITS-1:0] DUTY_MAX        = 10'd1000;
   localparam logic [5:0] BLINK_TIMEOUT = 6'd10;
   localparam logic [5:0] GLOW_TIMEOUT  = 6'd50;

   // One result transaction.
   typedef struct packed {
      logic                 led_lit;
      logic                 pin_level;
      logic [DUTY_BITS-1:0] pwm_duty;
      logic                 pwm_active;
      logic [3:0]           mode_now;
   } result_type;

   // Phase durations in milliseconds for each mode; unused phases are zero.
   function automatic logic [DUR_BITS-1:0] phase_duration(input logic [3:0] mode,
                                                         input logic [2:0] phase);
      logic [DUR_BITS-1:0] first;
      logic [DUR_BITS-1:0] second;
      logic [DUR_BITS-1:0] dur;
      first  = '0;
      second = '0;
      case (mode)
         MODE_FAST: begin
            first  = 14'd190;
            second = 14'd10;
         end
         MODE_BLINK: begin
            first  = 14'd1950;
            second = 14'd50;
         end
         MODE_INV: begin
            first  = 14'd1900;
            second = 14'd100;
         end
         MODE_TWICE: begin
            first  = 14'd1300;
            second = 14'd50;
         end
         MODE_SLOW: begin
            first  = 14'd4700;
            second = 14'd300;
         end
         MODE_SLOW_INV: begin
            first  = 14'd4800;
            second = 14'd200;
         end
         MODE_STANDBY: begin
            first  = 14'd9950;
            second = 14'd50;
         end
         default: begin
            first  = '0;
            second = '0;
         end
      endcase
      case (phase)
         3'd0: dur = first;
         3'd1: dur = second;
         3'd2: dur = (mode == MODE_TWICE) ? 14'd100 : 14'd0;
         3'd3: dur = (mode == MODE_TWICE) ? 14'd50 : 14'd0;
         default: dur = '0;
      endcase
      return dur;
   endfunction

endpackage

`default_nettype wire

>>> src/led_blink_pattern_sequencer.sv
// A result is registered in the result register, or in the skid entry if that register holds a stalled result.
// One transaction per cycle while req_stall is low; all state updates settle in a single pass.
// A result register plus one skid entry lets a request be taken while a result waits.
// Reset is synchronous and active high: mode off, LED dark, counters and duty zero,
// active_high 0 and glow_step 60; no result is pending after reset.
`default_nettype none
`include "led_blink_pattern_sequencer_assert.svh"

module led_blink_pattern_sequencer #(
   parameter int PHASES     = lbps_pkg::PHASES_DEFAULT,
   parameter int COUNT_BITS = lbps_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel.
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [1:0]                     req_cmd,
   input  wire logic [3:0]                     req_mode_sel,
   // Result channel.
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic                           rsp_led_lit,
   output      logic                           rsp_pin_level,
   output      logic [lbps_pkg::DUTY_BITS-1:0] rsp_pwm_duty,
   output      logic                           rsp_pwm_active,
   output      logic [3:0]                     rsp_mode_now,
   // Configuration write port.
   input  wire logic                           csr_wr_en,
   input  wire logic                           csr_index,
   input  wire logic [lbps_pkg::DUTY_BITS-1:0] csr_wdata
);

   localparam int DB = lbps_pkg::DUTY_BITS;

   // Configuration registers.
   logic          active_high_ff;
   logic [DB-1:0] glow_step_ff;

   // Sequencer state.
   logic [3:0]            mode_ff, mode_in;
   logic                  lit_ff, lit_in;
   logic [2:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] since_toggle_ff, since_toggle_in;
   logic [COUNT_BITS-1:0] since_update_ff, since_update_in;
   logic [DB-1:0]         duty_ff, duty_in;
   logic                  glow_rising_ff, glow_rising_in;

   // Output staging.
   logic                 rsp_valid_ff, rsp_valid_in;
   lbps_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   lbps_pkg::result_type skid_data_ff, skid_data_in;

   // Intermediate values of the update.
   logic                  accept;
   logic [COUNT_BITS-1:0] toggle_inc;
   logic [COUNT_BITS-1:0] update_inc;
   logic [COUNT_BITS-1:0] timeout;
   logic [3:0]            mode_plus;
   logic [3:0]            target_raw;
   logic [3:0]            target;
   logic [3:0]            phase_next;
   logic                  phase_wrap;
   logic [lbps_pkg::DUR_BITS-1:0] dur_now;
   logic [lbps_pkg::DUR_BITS-1:0] dur_next;
   logic signed [DB+1:0]  duty_sum;
   lbps_pkg::result_type  result;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;

   // Saturating elapsed-time counters.
   assign toggle_inc = (&since_toggle_ff) ? since_toggle_ff
                                          : since_toggle_ff + COUNT_BITS'(1);
   assign update_inc = (&since_update_ff) ? since_update_ff
                                          : since_update_ff + COUNT_BITS'(1);
   assign timeout    = (mode_ff == lbps_pkg::MODE_GLOW) ? COUNT_BITS'(lbps_pkg::GLOW_TIMEOUT)
                                                        : COUNT_BITS'(lbps_pkg::BLINK_TIMEOUT);

   // Mode targeted by a set or advance command; codes above on fall back to off.
   assign mode_plus  = mode_ff + 4'd1;
   assign target_raw = (req_cmd == lbps_pkg::CMD_SET) ? req_mode_sel : mode_plus;
   assign target     = (target_raw > lbps_pkg::MODE_ON) ? lbps_pkg::MODE_OFF : target_raw;

   // Pattern lookup for the current and following phase.
   assign dur_now    = lbps_pkg::phase_duration(mode_ff, phase_ff);
   assign phase_next = {1'b0, phase_ff} + 4'd1;
   assign dur_next   = lbps_pkg::phase_duration(mode_ff, phase_next[2:0]);
   assign phase_wrap = (phase_next >= 4'(PHASES)) || phase_next[3] || (dur_next == '0);

   // Glow ramp step in either direction.
   assign duty_sum = glow_rising_ff
                   ? $signed({2'b00, duty_ff}) + $signed({2'b00, glow_step_ff})
                   : $signed({2'b00, duty_ff}) - $signed({2'b00, glow_step_ff});

   // Next state for one request transaction.
   always_comb begin
      mode_in         = mode_ff;
      lit_in          = lit_ff;
      phase_in        = phase_ff;
      since_toggle_in = since_toggle_ff;
      since_update_in = since_update_ff;
      duty_in         = duty_ff;
      glow_rising_in  = glow_rising_ff;
      if (accept) begin
         case (req_cmd)
            lbps_pkg::CMD_TICK: begin
               since_toggle_in = toggle_inc;
               since_update_in = update_inc;
               if (mode_ff != lbps_pkg::MODE_OFF && mode_ff != lbps_pkg::MODE_ON &&
                   update_inc > timeout) begin
                  since_update_in = '0;
                  if (mode_ff == lbps_pkg::MODE_GLOW) begin
                     if (duty_sum >= $signed({2'b00, lbps_pkg::DUTY_MAX})) begin
                        duty_in        = lbps_pkg::DUTY_MAX;
                        glow_rising_in = !glow_rising_ff;
                     end else if (duty_sum <= 0) begin
                        duty_in        = '0;
                        glow_rising_in = !glow_rising_ff;
                     end else begin
                        duty_in = duty_sum[DB-1:0];
                     end
                  end else if (toggle_inc > COUNT_BITS'(dur_now)) begin
                     lit_in          = !lit_ff;
                     since_toggle_in = '0;
                     phase_in        = phase_wrap ? 3'd0 : phase_next[2:0];
                  end
               end
            end
            lbps_pkg::CMD_SET, lbps_pkg::CMD_NEXT: begin
               if (target != mode_ff) begin
                  mode_in         = target;
                  since_toggle_in = '0;
                  phase_in        = 3'd0;
                  lit_in          = (target == lbps_pkg::MODE_GLOW) ||
                                    (target == lbps_pkg::MODE_ON) ||
                                    (target == lbps_pkg::MODE_INV) ||
                                    (target == lbps_pkg::MODE_SLOW_INV);
                  if (target == lbps_pkg::MODE_GLOW) begin
                     duty_in        = '0;
                     glow_rising_in = 1'b0;
                  end
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Result fields from the updated state.
   always_comb begin
      result.led_lit    = lit_in;
      result.pwm_active = (mode_in == lbps_pkg::MODE_GLOW);
      result.pin_level  = result.pwm_active ? 1'b0
                        : (active_high_ff ? lit_in : !lit_in);
      result.pwm_duty   = result.pwm_active ? duty_in : '0;
      result.mode_now   = mode_in;
   end

   // Result register with one skid entry behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= lbps_pkg::MODE_OFF;
         lit_ff          <= 1'b0;
         phase_ff        <= 3'd0;
         since_toggle_ff <= '0;
         since_update_ff <= '0;
         duty_ff         <= '0;
         glow_rising_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         lit_ff          <= lit_in;
         phase_ff        <= phase_in;
         since_toggle_ff <= since_toggle_in;
         since_update_ff <= since_update_in;
         duty_ff         <= duty_in;
         glow_rising_ff  <= glow_rising_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff <= 1'b0;
         glow_step_ff   <= lbps_pkg::GLOW_STEP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lbps_pkg::CSR_ACTIVE_HIGH: active_high_ff <= csr_wdata[0];
            lbps_pkg::CSR_GLOW_STEP:   glow_step_ff   <= csr_wdata;
            default:                   glow_step_ff   <= glow_step_ff;
         endcase
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_lit    = rsp_data_ff.led_lit;
   assign rsp_pin_level  = rsp_data_ff.pin_level;
   assign rsp_pwm_duty   = rsp_data_ff.pwm_duty;
   assign rsp_pwm_active = rsp_data_ff.pwm_active;
   assign rsp_mode_now   = rsp_data_ff.mode_now;

   // The skid entry is only used while the result register is occupied.
   `LBPS_ASSERT_ALWAYS(a_skid_behind_rsp, clock, reset, !skid_valid_ff || rsp_valid_ff)
   // The glow duty never leaves its range.
   `LBPS_ASSERT_ALWAYS(a_duty_range, clock, reset, duty_ff <= lbps_pkg::DUTY_MAX)
   // The phase index stays inside the configured pattern length.
   `LBPS_ASSERT_ALWAYS(a_phase_range, clock, reset, {1'b0, phase_ff} < 4'(PHASES))
   // A valid set command lands in the mode register.
   `LBPS_ASSERT_NEXT(a_set_mode, clock, reset,
      accept && req_cmd == lbps_pkg::CMD_SET && req_mode_sel <= lbps_pkg::MODE_ON,
      mode_ff == $past(req_mode_sel))
   // A stalled result is never dropped.
   `LBPS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)

endmodule

`default_nettype wire
